FILE: rtl/lsga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsga_pkg;

  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = VAL_W + 8;
  localparam int OPB_W   = VAL_W + 1;
  localparam int PROD_W  = VAL_W + OPB_W;
  localparam int SPLIT_W = ACC_W / 2;
  localparam int FULL_W  = VAL_W + ACC_W;
  localparam int TERM_W  = 61;
  localparam int SUM_W   = TERM_W + 2;

  localparam int N_LANES = 4;
  localparam int N_DIRS  = 3;
  localparam int N_INV   = 9;
  localparam int N_ENTRY = 13;

  localparam logic [1:0] K_LAST   = 2'd2;
  localparam logic [1:0] VAR_LAST = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_NEIGH  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } lsga_cmd_e;

  typedef enum logic [1:0] {
    BSEL_DIFF = 2'd0,
    BSEL_LO   = 2'd1,
    BSEL_HI   = 2'd2
  } lsga_bsel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N_MUL,
    ST_N_CON,
    ST_N_ACC,
    ST_F_LO,
    ST_F_HI,
    ST_F_CMB,
    ST_F_TRM,
    ST_F_SUM,
    ST_F_OUT
  } lsga_state_e;

  typedef struct packed {
    logic       clr_acc;
    logic       diff_en;
    logic       mul_en;
    lsga_bsel_e b_sel;
    logic [1:0] k;
    logic       keep_lo;
    logic       comb_en;
    logic       term_en;
    logic       contrib_en;
    logic       acc_en;
    logic       sum_clr;
    logic       sum_en;
  } lsga_ctrl_t;

  // shift right by the fraction width, truncating toward zero
  function automatic logic signed [FULL_W-1:0] shr_tz(input logic signed [FULL_W-1:0] x);
    logic signed [FULL_W-1:0] bias;
    bias = x[FULL_W-1] ? {{(FULL_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}} : '0;
    return (x + bias) >>> FRAC_W;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [FULL_W-1:0] x);
    if (&x[FULL_W-1:ACC_W-1] || ~|x[FULL_W-1:ACC_W-1]) return x[ACC_W-1:0];
    return x[FULL_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [FULL_W-1:0] x);
    if (&x[FULL_W-1:TERM_W-1] || ~|x[FULL_W-1:TERM_W-1]) return x[TERM_W-1:0];
    return x[FULL_W-1] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    if (&x[SUM_W-1:VAL_W-1] || ~|x[SUM_W-1:VAL_W-1]) return x[VAL_W-1:0];
    return x[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/least_squares_gradient_apply.sv
`timescale 1ns / 1ps
`default_nettype none

// Load: taken while idle, busy stays low. Neighbour: the diff is taken with the beat,
// then busy through the multiply, scale and accumulate steps; no new item is taken until they end.
// Finish: 3 matrix columns x 5 steps (two split products per column), then four
// results on consecutive cycles; the next beat is taken once the last result is out.
// The receiver cannot stall results.
// Reset (asynchronous, active low) clears the matrix, centre values and accumulators.
module least_squares_gradient_apply import lsga_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              command_i,
  input  wire logic [3:0]              entry_index_i,
  input  wire logic signed [VAL_W-1:0] entry_value_i,
  input  wire logic signed [VAL_W-1:0] weight_x_i,
  input  wire logic signed [VAL_W-1:0] weight_y_i,
  input  wire logic signed [VAL_W-1:0] weight_z_i,
  input  wire logic signed [VAL_W-1:0] neighbour_rho_i,
  input  wire logic signed [VAL_W-1:0] neighbour_u_i,
  input  wire logic signed [VAL_W-1:0] neighbour_v_i,
  input  wire logic signed [VAL_W-1:0] neighbour_w_i,
  output logic                         valid_o,
  output logic [1:0]                   variable_o,
  output logic signed [VAL_W-1:0]      grad_x_o,
  output logic signed [VAL_W-1:0]      grad_y_o,
  output logic signed [VAL_W-1:0]      grad_z_o,
  output logic                         last_o
);

  lsga_state_e state_q, state_d;
  logic [1:0]  k_q, k_d;
  logic [1:0]  q_q, q_d;
  lsga_ctrl_t  ctl;
  logic        emit;
  logic        accept;

  logic signed [VAL_W-1:0] inv_q    [N_INV];
  logic signed [VAL_W-1:0] centre_q [N_LANES];
  logic signed [VAL_W-1:0] w_q      [N_DIRS];
  logic signed [VAL_W-1:0] a        [N_DIRS];
  logic signed [VAL_W-1:0] nb       [N_LANES];
  logic signed [SUM_W-1:0] sums     [N_LANES][N_DIRS];
  logic [3:0]              centre_idx;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign nb[0] = neighbour_rho_i;
  assign nb[1] = neighbour_u_i;
  assign nb[2] = neighbour_v_i;
  assign nb[3] = neighbour_w_i;

  assign centre_idx = entry_index_i - 4'(N_INV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      q_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      q_q     <= q_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_INV; i++) inv_q[i] <= '0;
      for (int i = 0; i < N_LANES; i++) centre_q[i] <= '0;
    end else if (accept && lsga_cmd_e'(command_i) == CMD_LOAD) begin
      if (entry_index_i < 4'(N_INV)) begin
        inv_q[entry_index_i] <= entry_value_i;
      end else if (entry_index_i < 4'(N_ENTRY)) begin
        centre_q[centre_idx[1:0]] <= entry_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && lsga_cmd_e'(command_i) == CMD_NEIGH) begin
      w_q[0] <= weight_x_i;
      w_q[1] <= weight_y_i;
      w_q[2] <= weight_z_i;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    q_d     = q_q;
    ctl     = '0;
    ctl.k   = k_q;
    emit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (lsga_cmd_e'(command_i))
            CMD_LOAD: ctl.clr_acc = 1'b1;
            CMD_NEIGH: begin
              ctl.diff_en = 1'b1;
              state_d     = ST_N_MUL;
            end
            CMD_FINISH: begin
              ctl.sum_clr = 1'b1;
              k_d         = '0;
              state_d     = ST_F_LO;
            end
            default: ;
          endcase
        end
      end
      ST_N_MUL: begin
        ctl.mul_en = 1'b1;
        ctl.b_sel  = BSEL_DIFF;
        state_d    = ST_N_CON;
      end
      ST_N_CON: begin
        ctl.contrib_en = 1'b1;
        state_d        = ST_N_ACC;
      end
      ST_N_ACC: begin
        ctl.acc_en = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_F_LO: begin
        ctl.mul_en = 1'b1;
        ctl.b_sel  = BSEL_LO;
        state_d    = ST_F_HI;
      end
      ST_F_HI: begin
        ctl.mul_en  = 1'b1;
        ctl.b_sel   = BSEL_HI;
        ctl.keep_lo = 1'b1;
        state_d     = ST_F_CMB;
      end
      ST_F_CMB: begin
        ctl.comb_en = 1'b1;
        state_d     = ST_F_TRM;
      end
      ST_F_TRM: begin
        ctl.term_en = 1'b1;
        state_d     = ST_F_SUM;
      end
      ST_F_SUM: begin
        ctl.sum_en = 1'b1;
        if (k_q == K_LAST) begin
          q_d     = '0;
          state_d = ST_F_OUT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_F_LO;
        end
      end
      ST_F_OUT: begin
        emit = 1'b1;
        if (q_q == VAR_LAST) begin
          state_d = ST_IDLE;
        end else begin
          q_d = q_q + 2'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar d = 0; d < N_DIRS; d++) begin : g_opa
    logic [3:0] inv_idx;
    assign inv_idx = 4'(N_DIRS * d) + {2'b00, k_q};
    assign a[d] = (state_q == ST_F_LO || state_q == ST_F_HI) ? inv_q[inv_idx] : w_q[d];
  end

  for (genvar q = 0; q < N_LANES; q++) begin : g_lane
    lsga_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .a_i      (a),
      .nb_i     (nb[q]),
      .centre_i (centre_q[q]),
      .sum_o    (sums[q])
    );
  end

  lsga_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .sel_i      (q_q),
    .sums_i     (sums),
    .valid_o    (valid_o),
    .variable_o (variable_o),
    .grad_x_o   (grad_x_o),
    .grad_y_o   (grad_y_o),
    .grad_z_o   (grad_z_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/lsga_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module lsga_lane import lsga_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lsga_ctrl_t              ctl_i,
  input  wire logic signed [VAL_W-1:0] a_i [N_DIRS],
  input  wire logic signed [VAL_W-1:0] nb_i,
  input  wire logic signed [VAL_W-1:0] centre_i,
  output logic signed [SUM_W-1:0]      sum_o [N_DIRS]
);

  logic signed [OPB_W-1:0]  diff_q;
  logic signed [OPB_W-1:0]  b;
  logic signed [ACC_W-1:0]  acc_q     [N_DIRS];
  logic signed [PROD_W-1:0] prod_q    [N_DIRS];
  logic signed [PROD_W-1:0] plo_q     [N_DIRS];
  logic signed [FULL_W-1:0] full_q    [N_DIRS];
  logic signed [TERM_W-1:0] term_q    [N_DIRS];
  logic signed [ACC_W-1:0]  contrib_q [N_DIRS];
  logic signed [SUM_W-1:0]  sum_q     [N_DIRS];
  logic signed [ACC_W-1:0]  acc_k;

  assign acc_k = acc_q[ctl_i.k];

  always_comb begin
    case (ctl_i.b_sel)
      BSEL_DIFF: b = diff_q;
      BSEL_LO:   b = {{(OPB_W-SPLIT_W){1'b0}}, acc_k[SPLIT_W-1:0]};
      BSEL_HI:   b = {{(OPB_W-(ACC_W-SPLIT_W)){acc_k[ACC_W-1]}}, acc_k[ACC_W-1:SPLIT_W]};
      default:   b = diff_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.diff_en) begin
      diff_q <= OPB_W'(nb_i) - OPB_W'(centre_i);
    end
  end

  for (genvar d = 0; d < N_DIRS; d++) begin : g_dir
    logic signed [PROD_W-1:0] mul_w;
    logic signed [ACC_W:0]    acc_sum;

    assign mul_w   = PROD_W'(a_i[d]) * PROD_W'(b);
    assign acc_sum = {acc_q[d][ACC_W-1], acc_q[d]} + {contrib_q[d][ACC_W-1], contrib_q[d]};

    always_ff @(posedge clk_i) begin
      if (ctl_i.mul_en) begin
        prod_q[d] <= mul_w;
      end
      if (ctl_i.keep_lo) begin
        plo_q[d] <= prod_q[d];
      end
      if (ctl_i.comb_en) begin
        full_q[d] <= (FULL_W'(prod_q[d]) <<< SPLIT_W) + FULL_W'(plo_q[d]);
      end
      if (ctl_i.term_en) begin
        term_q[d] <= sat_term(shr_tz(full_q[d]));
      end
      if (ctl_i.contrib_en) begin
        contrib_q[d] <= sat_acc(shr_tz(FULL_W'(prod_q[d])));
      end
      if (ctl_i.sum_clr) begin
        sum_q[d] <= '0;
      end else if (ctl_i.sum_en) begin
        sum_q[d] <= sum_q[d] + SUM_W'(term_q[d]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[d] <= '0;
      end else if (ctl_i.clr_acc) begin
        acc_q[d] <= '0;
      end else if (ctl_i.acc_en) begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
          acc_q[d] <= acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_q[d] <= acc_sum[ACC_W-1:0];
        end
      end
    end

    assign sum_o[d] = sum_q[d];
  end

endmodule

`default_nettype wire

FILE: rtl/lsga_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module lsga_merge import lsga_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    emit_i,
  input  wire logic [1:0]              sel_i,
  input  wire logic signed [SUM_W-1:0] sums_i [N_LANES][N_DIRS],
  output logic                         valid_o,
  output logic [1:0]                   variable_o,
  output logic signed [VAL_W-1:0]      grad_x_o,
  output logic signed [VAL_W-1:0]      grad_y_o,
  output logic signed [VAL_W-1:0]      grad_z_o,
  output logic                         last_o
);

  logic                    valid_q;
  logic [1:0]              variable_q;
  logic signed [VAL_W-1:0] gx_q, gy_q, gz_q;
  logic                    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      variable_q <= sel_i;
      gx_q       <= sat_val(sums_i[sel_i][0]);
      gy_q       <= sat_val(sums_i[sel_i][1]);
      gz_q       <= sat_val(sums_i[sel_i][2]);
      last_q     <= (sel_i == VAR_LAST);
    end
  end

  assign valid_o    = valid_q;
  assign variable_o = variable_q;
  assign grad_x_o   = gx_q;
  assign grad_y_o   = gy_q;
  assign grad_z_o   = gz_q;
  assign last_o     = valid_q && last_q;

endmodule

`default_nettype wire

FILE: rtl/lsga_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lsga_checker import lsga_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       valid_i,
  input wire logic [1:0] variable_i,
  input wire logic       last_i
);

  a_beat_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !valid_i)
    else $error("result appeared right after an input beat");

  a_busy_midcell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |-> busy)
    else $error("busy dropped before the last result of a cell");

  a_results_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |=> valid_i && variable_i == $past(variable_i) + 2'd1)
    else $error("results of a cell not contiguous or out of order");

  a_last_is_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i |-> valid_i && variable_i == VAR_LAST)
    else $error("last marked on the wrong result");

endmodule

bind least_squares_gradient_apply lsga_checker u_lsga_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_i    (valid_o),
  .variable_i (variable_o),
  .last_i     (last_o)
);

`default_nettype wire
